// ===== rtl/core/arith_geometric_mean_unit_macros.svh =====
// Assertion helpers for the AGM unit.
// Both sample on clk and are switched off while rst_n is low.
`ifndef ARITH_GEOMETRIC_MEAN_UNIT_MACROS_SVH
`define ARITH_GEOMETRIC_MEAN_UNIT_MACROS_SVH

// Same-cycle implication.
`define AGM_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("agm assertion failed");

// Next-cycle implication.
`define AGM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("agm assertion failed");

`endif

// ===== rtl/core/agm_pkg.sv =====
package agm_pkg;

  // Operand and result word width (unsigned fixed point)
  localparam int unsigned DATA_W = 32;
  // Product width fed to the square root
  localparam int unsigned PROD_W = 2 * DATA_W;
  // One root bit per cycle
  localparam int unsigned SQRT_STEPS = DATA_W;
  // Default cap on rounds
  localparam int unsigned MAX_ROUNDS_DEF = 8;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_EVAL = 4'b1000
  } agm_state_t;

endpackage

// ===== rtl/core/arith_geometric_mean_unit.sv =====
// Arithmetic-geometric mean of two unsigned fixed-point words.
//
// Input: drive in_first_value / in_second_value and raise start; the word is
// taken at the rising edge where start is high and busy is low. busy stays
// high until the result is out.
// Output: out_valid is high for exactly one cycle with out_mean and
// out_round_cap_hit; the receiver cannot stall, so the result must be taken
// in that cycle. busy is already low in that cycle, so the next word can be
// started at the edge that ends it.
// Each round runs ST_MUL for the 32x32 product and the halved sum, then
// ST_SQRT for the bit-serial square root (one root bit a cycle through a single
// subtract/compare), then ST_EVAL to check convergence. Between 2 and MAX_ROUNDS
// rounds run before out_valid is raised with the result.
// Rounds stop once the geometric mean no longer rises below a falling
// arithmetic mean; out_round_cap_hit marks a stop forced by MAX_ROUNDS.
// Synchronous reset (rst_n low) returns the sequencer to idle, drops busy
// and out_valid; no work in flight survives it.
module arith_geometric_mean_unit #(
  parameter int unsigned MAX_ROUNDS = agm_pkg::MAX_ROUNDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [agm_pkg::DATA_W-1:0] in_first_value,
  input  logic [agm_pkg::DATA_W-1:0] in_second_value,
  output logic                       out_valid,
  output logic [agm_pkg::DATA_W-1:0] out_mean,
  output logic                       out_round_cap_hit
);
  import agm_pkg::*;

`include "arith_geometric_mean_unit_macros.svh"

  localparam int unsigned RND_W = $clog2(MAX_ROUNDS + 1);
  localparam int unsigned CNT_W = $clog2(SQRT_STEPS);
  localparam int unsigned REM_W = DATA_W + 2;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SQRT_STEPS - 1);
  localparam logic [RND_W-1:0] RND_CAP  = RND_W'(MAX_ROUNDS);

  // Control state
  agm_state_t        state_r, state_nxt;
  logic [RND_W-1:0]  rounds_r, rounds_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath
  logic [DATA_W-1:0] g_r, g_nxt;       // previous geometric mean
  logic [DATA_W-1:0] a_r, a_nxt;       // previous arithmetic mean
  logic [DATA_W-1:0] new_a_r, new_a_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt; // radicand, shifted out two bits a step
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DATA_W-1:0] root_r, root_nxt;
  logic [DATA_W-1:0] mean_r, mean_nxt;
  logic              cap_r, cap_nxt;

  // Shared arithmetic
  logic [PROD_W-1:0] prod_w;
  logic [DATA_W:0]   sum_w;
  logic [REM_W-1:0]  rem_sh_w;
  logic [REM_W-1:0]  trial_w;
  logic              fits_w;
  logic [RND_W-1:0]  rounds_done_w;
  logic              keep_w;

  assign prod_w   = PROD_W'(g_r) * PROD_W'(a_r);
  assign sum_w    = {1'b0, g_r} + {1'b0, a_r};
  // root digit step: bring down two radicand bits, try (4*root + 1)
  assign rem_sh_w = {rem_r[REM_W-3:0], prod_r[PROD_W-1 -: 2]};
  assign trial_w  = {root_r, 2'b01};
  assign fits_w   = (rem_sh_w >= trial_w);

  assign rounds_done_w = rounds_r + 1'b1;
  assign keep_w = (root_r < new_a_r) && (root_r > g_r) && (new_a_r < a_r);

  // Sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    rounds_nxt    = rounds_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    g_nxt         = g_r;
    a_nxt         = a_r;
    new_a_nxt     = new_a_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    mean_nxt      = mean_r;
    cap_nxt       = cap_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          g_nxt      = in_first_value;
          a_nxt      = in_second_value;
          rounds_nxt = '0;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = prod_w;
        new_a_nxt = sum_w[DATA_W:1];
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        prod_nxt = {prod_r[PROD_W-3:0], 2'b00};
        if (fits_w) begin
          rem_nxt  = rem_sh_w - trial_w;
          root_nxt = {root_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh_w;
          root_nxt = {root_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        rounds_nxt = rounds_done_w;
        g_nxt      = root_r;
        a_nxt      = new_a_r;
        if (rounds_r == '0) begin
          // first round only seeds the pair
          state_nxt = ST_MUL;
        end else if (!keep_w) begin
          mean_nxt      = root_r;
          cap_nxt       = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (rounds_done_w >= RND_CAP) begin
          mean_nxt      = root_r;
          cap_nxt       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rounds_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rounds_r    <= rounds_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    g_r     <= g_nxt;
    a_r     <= a_nxt;
    new_a_r <= new_a_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    mean_r  <= mean_nxt;
    cap_r   <= cap_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_mean          = mean_r;
  assign out_round_cap_hit = cap_r;

  // Checks
  `AGM_ASSERT_NOW(a_result_when_idle, out_valid, !busy)
  `AGM_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
  `AGM_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `AGM_ASSERT_NOW(a_cap_at_limit, out_valid && out_round_cap_hit, rounds_r == RND_CAP)
  `AGM_ASSERT_NOW(a_min_two_rounds, out_valid, rounds_r >= RND_W'(2))

endmodule
